>>> rtl/bffa_pkg.sv
// shared constants and types for the best-fit frame allocator
package bffa_pkg;

  localparam int FRAME_COUNT = 256;
  localparam int IDX_W       = $clog2(FRAME_COUNT);
  localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int TAG_W       = 5;
  localparam int NEED_W      = 9;
  localparam int CMP_W       = (CNT_W > NEED_W) ? CNT_W : NEED_W;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_COMPACTED = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_RELEASED  = 2'd3
  } status_t;

  localparam logic [TAG_W-1:0] TAG_FREE = '0;

endpackage

>>> rtl/bffa_ram.sv
// generic simple dual-port ram with registered read
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/best_fit_frame_allocator.sv
// best-fit contiguous frame allocator with compaction, top level
// The frame owner tags live in one RAM that is swept one frame per cycle.
// After reset a clearing pass over all FRAME_COUNT (256) frames zeroes the
// RAM before the first word is taken. Per word: a release sweeps all frames;
// an allocate scans all frames and then fills the run, or on compaction
// sweeps the store again and rewrites its tail; rejects of owner zero or
// length zero skip the sweep. One word is in work at a time; a finished
// result waits in the output register while the next word is taken.
module best_fit_frame_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [bffa_pkg::TAG_W-1:0]    in_owner,
  input  logic [bffa_pkg::NEED_W-1:0]   in_frames_needed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_start_frame,
  output logic [8:0]                    out_frames_moved,
  output logic [8:0]                    out_frames_freed
);
  import bffa_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_REL   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_FILL  = 8'b0001_0000,
    S_COMP  = 8'b0010_0000,
    S_ZERO  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rv_r, rv_nxt;
  logic [IDX_W-1:0]    ridx_r, ridx_nxt;
  logic [TAG_W-1:0]    owner_r, owner_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [CNT_W-1:0]    run_len_r, run_len_nxt;
  logic [IDX_W-1:0]    run_start_r, run_start_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    best_len_r, best_len_nxt;
  logic [IDX_W-1:0]    best_start_r, best_start_nxt;
  logic [CNT_W-1:0]    free_r, free_nxt;
  logic [CNT_W-1:0]    w_r, w_nxt;
  logic [NEED_W-1:0]   rem_r, rem_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_start_r, res_start_nxt;
  logic [CNT_W-1:0]    res_moved_r, res_moved_nxt;
  logic [CNT_W-1:0]    res_freed_r, res_freed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [7:0]          out_start_r, out_start_nxt;
  logic [8:0]          out_moved_r, out_moved_nxt;
  logic [8:0]          out_freed_r, out_freed_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [TAG_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [TAG_W-1:0]    ram_rdata;

  bffa_ram #(
    .WIDTH(TAG_W),
    .DEPTH(FRAME_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sweep control and per-frame processing
  always_comb begin
    logic             sweep;
    logic             issue;
    logic             last;
    logic             is_free;
    logic [CNT_W-1:0] close_len;
    logic [IDX_W-1:0] close_start;
    logic             found_n;
    logic [IDX_W-1:0] best_start_n;
    logic [CNT_W-1:0] free_n;
    logic [CNT_W-1:0] w_n;
    logic [CNT_W-1:0] offs;
    logic [CMP_W-1:0] ext_start;
    logic [CMP_W-1:0] ext_moved;
    logic [CMP_W-1:0] ext_freed;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    owner_nxt      = owner_r;
    need_nxt       = need_r;
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    found_nxt      = found_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    free_nxt       = free_r;
    w_nxt          = w_r;
    rem_nxt        = rem_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_moved_nxt  = res_moved_r;
    res_freed_nxt  = res_freed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_moved_nxt  = out_moved_r;
    out_freed_nxt  = out_freed_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDX_W-1:0];
    ram_wdata      = TAG_FREE;

    // read issue for the three sweeping states
    sweep     = (state_r == S_REL) || (state_r == S_SCAN) || (state_r == S_COMP);
    issue     = sweep && (cnt_r < CNT_W'(FRAME_COUNT));
    ram_re    = issue;
    ram_raddr = cnt_r[IDX_W-1:0];
    rv_nxt    = issue;
    ridx_nxt  = cnt_r[IDX_W-1:0];
    if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    last    = rv_r && (ridx_r == IDX_W'(FRAME_COUNT - 1));
    is_free = (ram_rdata == TAG_FREE);

    // hole that closes at this frame
    close_len    = is_free ? run_len_r + 1'b1 : run_len_r;
    close_start  = (is_free && run_len_r == '0) ? ridx_r : run_start_r;
    found_n      = found_r;
    best_start_n = best_start_r;
    free_n       = free_r;
    w_n          = w_r;
    offs         = cnt_r - w_r;
    ext_start    = CMP_W'(res_start_r);
    ext_moved    = CMP_W'(res_moved_r);
    ext_freed    = CMP_W'(res_freed_r);

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAME_COUNT - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          owner_nxt   = in_owner;
          need_nxt    = in_frames_needed;
          cnt_nxt     = '0;
          w_nxt       = '0;
          run_len_nxt = '0;
          found_nxt   = 1'b0;
          free_nxt    = '0;
          if (in_mode) begin
            state_nxt = S_REL;
          end else if (in_owner == TAG_FREE || in_frames_needed == '0) begin
            res_status_nxt = ST_REJECTED;
            res_start_nxt  = '0;
            res_moved_nxt  = '0;
            res_freed_nxt  = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_REL: begin
        if (rv_r) begin
          if (owner_r != TAG_FREE && ram_rdata == owner_r) begin
            ram_we    = 1'b1;
            ram_waddr = ridx_r;
            w_n       = w_r + 1'b1;
          end
          w_nxt = w_n;
          if (last) begin
            res_status_nxt = ST_RELEASED;
            res_start_nxt  = '0;
            res_moved_nxt  = '0;
            res_freed_nxt  = w_n;
            state_nxt      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (rv_r) begin
          if (is_free) begin
            run_len_nxt   = close_len;
            run_start_nxt = close_start;
            free_n        = free_r + 1'b1;
          end else begin
            run_len_nxt = '0;
          end
          free_nxt = free_n;
          if ((!is_free || last) && CMP_W'(close_len) >= CMP_W'(need_r) &&
              (!found_r || close_len < best_len_r)) begin
            found_n      = 1'b1;
            best_start_n = close_start;
            best_len_nxt = close_len;
          end
          found_nxt      = found_n;
          best_start_nxt = best_start_n;
          if (last) begin
            if (found_n) begin
              cnt_nxt   = CNT_W'(best_start_n);
              rem_nxt   = need_r;
              state_nxt = S_FILL;
            end else if (CMP_W'(free_n) >= CMP_W'(need_r)) begin
              cnt_nxt   = '0;
              w_nxt     = '0;
              state_nxt = S_COMP;
            end else begin
              res_status_nxt = ST_REJECTED;
              res_start_nxt  = '0;
              res_moved_nxt  = '0;
              res_freed_nxt  = '0;
              state_nxt      = S_DONE;
            end
          end
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = owner_r;
        cnt_nxt   = cnt_r + 1'b1;
        rem_nxt   = rem_r - 1'b1;
        if (rem_r == NEED_W'(1)) begin
          res_status_nxt = ST_PLACED;
          res_start_nxt  = best_start_r;
          res_moved_nxt  = '0;
          res_freed_nxt  = '0;
          state_nxt      = S_DONE;
        end
      end
      S_COMP: begin
        if (rv_r) begin
          if (!is_free) begin
            ram_we    = 1'b1;
            ram_waddr = w_r[IDX_W-1:0];
            ram_wdata = ram_rdata;
            w_n       = w_r + 1'b1;
          end
          w_nxt = w_n;
          if (last) begin
            cnt_nxt   = w_n;
            state_nxt = S_ZERO;
          end
        end
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_wdata = (CMP_W'(offs) < CMP_W'(need_r)) ? owner_r : TAG_FREE;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAME_COUNT - 1)) begin
          res_status_nxt = ST_COMPACTED;
          res_start_nxt  = w_r[IDX_W-1:0];
          res_moved_nxt  = w_r;
          res_freed_nxt  = '0;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = ext_start[7:0];
          out_moved_nxt  = ext_moved[8:0];
          out_freed_nxt  = ext_freed[8:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ridx_r       <= ridx_nxt;
    owner_r      <= owner_nxt;
    need_r       <= need_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    found_r      <= found_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    free_r       <= free_nxt;
    w_r          <= w_nxt;
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_moved_r  <= res_moved_nxt;
    res_freed_r  <= res_freed_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_moved_r  <= out_moved_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_start_frame  = out_start_r;
  assign out_frames_moved = out_moved_r;
  assign out_frames_freed = out_freed_r;

  // state encoding stays one-hot
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");

  // a sweep never writes the frame it is reading
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write hit the same frame");

  // compaction write pointer never passes the frame being read back
  a_comp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && rv_r) |-> (w_r <= CNT_W'(ridx_r)))
    else $error("compaction write pointer ahead of read");

  // an accepted word always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start");

endmodule
